[rtl/signed_integer_to_decimal_text_macros.svh]
// Assertion macros for the signed integer to decimal text block.
// Used by the top level only; no other dependencies.
`ifndef SIGNED_INTEGER_TO_DECIMAL_TEXT_MACROS_SVH
`define SIGNED_INTEGER_TO_DECIMAL_TEXT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define SIDT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("sidt: same-cycle check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define SIDT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("sidt: next-cycle check failed");

`endif

[rtl/sidt_pkg.sv]
// Package for the signed integer to decimal text block: widths, character codes
// and the sequencer state type. No dependencies.
`default_nettype none

package sidt_pkg;

    // Width of the integer taken from the input field (8..64).
    localparam int VALUE_BITS = 64;
    localparam int INPUT_BITS = 64;
    localparam int CHAR_BITS  = 6;

    // Decimal digits of the largest magnitude 2^(VALUE_BITS-1).
    localparam int NUM_DIGITS = ((VALUE_BITS - 1) * 30103) / 100000 + 1;
    localparam int BCD_BITS   = 4 * NUM_DIGITS;
    localparam int BIT_CNT_W  = $clog2(VALUE_BITS);
    localparam int DIG_CNT_W  = $clog2(NUM_DIGITS + 1);

    localparam logic [CHAR_BITS-1:0] CHAR_ZERO  = 6'd48;
    localparam logic [CHAR_BITS-1:0] CHAR_MINUS = 6'd45;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_CONV = 5'b00010,
        ST_SKIP = 5'b00100,
        ST_SIGN = 5'b01000,
        ST_EMIT = 5'b10000
    } state_t;

endpackage

`default_nettype wire

[rtl/signed_integer_to_decimal_text.sv]
// Top level of the signed integer to decimal text converter.
// Depends on sidt_pkg and signed_integer_to_decimal_text_macros.svh.
//
//   channel   ports                          direction  carries
//   input     s_valid s_ready s_value        in         one signed integer per item
//   result    m_valid m_ready m_text_char    out        one ASCII character per item,
//             m_last_char                               last_char marks end of number
//
// Sequence: an integer is loaded in idle, then converted by shift-add-3 (one
//   magnitude bit per cycle into the BCD register); leading zero digits are then
//   dropped, a minus is sent if the integer is negative, and the digits follow;
//   dropped plus sent digits make NUM_DIGITS.
// Reset: aresetn is synchronous, active low; it returns the sequencer to idle and
//   empties the output register.
// Stalls: m_ready low holds the current character in the output register and
//   freezes the character sequencer; s_ready is high only in idle, which is
//   entered as the last character is loaded, so a new integer is taken while
//   that character still waits.
`default_nettype none
`include "signed_integer_to_decimal_text_macros.svh"

module signed_integer_to_decimal_text (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic [sidt_pkg::INPUT_BITS-1:0] s_value,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic [sidt_pkg::CHAR_BITS-1:0]      m_text_char,
    output logic                                m_last_char
);

    // Control state
    sidt_pkg::state_t                   state_reg, state_next;
    logic [sidt_pkg::BIT_CNT_W-1:0]     bit_cnt_reg, bit_cnt_next;
    logic [sidt_pkg::DIG_CNT_W-1:0]     dig_cnt_reg, dig_cnt_next;
    logic                               m_valid_reg, m_valid_next;

    // Datapath
    logic                               neg_reg, neg_next;
    logic [sidt_pkg::VALUE_BITS-1:0]    mag_reg, mag_next;
    logic [sidt_pkg::BCD_BITS-1:0]      bcd_reg, bcd_next;
    logic [sidt_pkg::CHAR_BITS-1:0]     char_reg, char_next;
    logic                               last_reg, last_next;

    logic [sidt_pkg::VALUE_BITS-1:0]    in_bits;
    logic [sidt_pkg::VALUE_BITS-1:0]    in_mag;
    logic [sidt_pkg::BCD_BITS-1:0]      bcd_adj;
    logic [3:0]                         top_digit;
    logic                               in_fire;
    logic                               out_free;

    // Conditions watched by the assertions
    logic                               emit_now;
    logic                               skip_or_emit;
    logic                               minus_shown;
    logic                               last_load;

    assign s_ready     = (state_reg == sidt_pkg::ST_IDLE);
    assign in_fire     = s_valid && s_ready;
    assign out_free    = !m_valid_reg || m_ready;
    assign m_valid     = m_valid_reg;
    assign m_text_char = char_reg;
    assign m_last_char = last_reg;

    // Take the low VALUE_BITS bits as two's complement; the most negative value
    // negates to itself, which read unsigned is exactly 2^(VALUE_BITS-1).
    assign in_bits   = s_value[sidt_pkg::VALUE_BITS-1:0];
    assign in_mag    = in_bits[sidt_pkg::VALUE_BITS-1]
                       ? sidt_pkg::VALUE_BITS'(~in_bits + 1'b1) : in_bits;
    assign top_digit = bcd_reg[sidt_pkg::BCD_BITS-1 -: 4];

    // Add 3 to every BCD digit of 5 or more ahead of the shift, so that the
    // doubling carries correctly into the next digit.
    always_comb begin
        for (int i = 0; i < sidt_pkg::NUM_DIGITS; i++) begin
            if (bcd_reg[4*i +: 4] >= 4'd5) begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            end else begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4];
            end
        end
    end

    always_comb begin
        state_next   = state_reg;
        bit_cnt_next = bit_cnt_reg;
        dig_cnt_next = dig_cnt_reg;
        neg_next     = neg_reg;
        mag_next     = mag_reg;
        bcd_next     = bcd_reg;
        char_next    = char_reg;
        last_next    = last_reg;
        // Drop the shown character once taken; a load below overrides this.
        m_valid_next = m_valid_reg && !m_ready;

        case (state_reg)
            sidt_pkg::ST_IDLE: begin
                if (in_fire) begin
                    neg_next     = in_bits[sidt_pkg::VALUE_BITS-1];
                    mag_next     = in_mag;
                    bcd_next     = '0;
                    bit_cnt_next = '0;
                    state_next   = sidt_pkg::ST_CONV;
                end
            end
            sidt_pkg::ST_CONV: begin
                // Shift one magnitude bit, most significant first, into the BCD digits.
                bcd_next = {bcd_adj[sidt_pkg::BCD_BITS-2:0], mag_reg[sidt_pkg::VALUE_BITS-1]};
                mag_next = {mag_reg[sidt_pkg::VALUE_BITS-2:0], 1'b0};
                bit_cnt_next = bit_cnt_reg + 1'b1;
                if (bit_cnt_reg == sidt_pkg::BIT_CNT_W'(sidt_pkg::VALUE_BITS - 1)) begin
                    dig_cnt_next = sidt_pkg::DIG_CNT_W'(sidt_pkg::NUM_DIGITS);
                    state_next   = sidt_pkg::ST_SKIP;
                end
            end
            sidt_pkg::ST_SKIP: begin
                // Drop leading zero digits, but keep the last one so zero prints '0'.
                if (top_digit == 4'd0 && dig_cnt_reg != sidt_pkg::DIG_CNT_W'(1)) begin
                    bcd_next     = {bcd_reg[sidt_pkg::BCD_BITS-5:0], 4'd0};
                    dig_cnt_next = dig_cnt_reg - 1'b1;
                end else if (neg_reg) begin
                    state_next = sidt_pkg::ST_SIGN;
                end else begin
                    state_next = sidt_pkg::ST_EMIT;
                end
            end
            sidt_pkg::ST_SIGN: begin
                if (out_free) begin
                    char_next    = sidt_pkg::CHAR_MINUS;
                    last_next    = 1'b0;
                    m_valid_next = 1'b1;
                    state_next   = sidt_pkg::ST_EMIT;
                end
            end
            sidt_pkg::ST_EMIT: begin
                if (out_free) begin
                    char_next    = sidt_pkg::CHAR_ZERO + {2'b00, top_digit};
                    last_next    = (dig_cnt_reg == sidt_pkg::DIG_CNT_W'(1));
                    m_valid_next = 1'b1;
                    bcd_next     = {bcd_reg[sidt_pkg::BCD_BITS-5:0], 4'd0};
                    dig_cnt_next = dig_cnt_reg - 1'b1;
                    if (dig_cnt_reg == sidt_pkg::DIG_CNT_W'(1)) begin
                        state_next = sidt_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = sidt_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= sidt_pkg::ST_IDLE;
            bit_cnt_reg <= '0;
            dig_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            bit_cnt_reg <= bit_cnt_next;
            dig_cnt_reg <= dig_cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge aclk) begin
        neg_reg  <= neg_next;
        mag_reg  <= mag_next;
        bcd_reg  <= bcd_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign emit_now     = (state_reg == sidt_pkg::ST_EMIT);
    assign skip_or_emit = (state_reg == sidt_pkg::ST_SKIP) || emit_now;
    assign minus_shown  = m_valid_reg && (char_reg == sidt_pkg::CHAR_MINUS);
    assign last_load    = emit_now && out_free && (dig_cnt_reg == sidt_pkg::DIG_CNT_W'(1));

    // A digit sent out must be a valid decimal digit after the shift-add-3 pass.
    `SIDT_ASSERT_NOW(a_emit_digit_bcd, aclk, aresetn, emit_now, top_digit <= 4'd9)
    // The digit count never runs out while digits are still skipped or sent.
    `SIDT_ASSERT_NOW(a_dig_cnt_live, aclk, aresetn, skip_or_emit, dig_cnt_reg != '0)
    // A minus sign is never the end of a number.
    `SIDT_ASSERT_NOW(a_minus_not_last, aclk, aresetn, minus_shown, !last_reg)
    // Loading the last character returns the sequencer to idle.
    `SIDT_ASSERT_NEXT(a_last_to_idle, aclk, aresetn, last_load, s_ready && m_valid && m_last_char)

endmodule

`default_nettype wire

[sim/decimal_text_checker.sv]
`timescale 1ns / 100ps
// Checker for signed_integer_to_decimal_text: predicts the decimal text of every
// accepted integer and compares each result item against it, field by field.
// Depends on sidt_pkg only.
module decimal_text_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    input  logic                            s_ready,
    input  logic [sidt_pkg::INPUT_BITS-1:0] s_value,
    input  logic                            m_valid,
    input  logic                            m_ready,
    input  logic [sidt_pkg::CHAR_BITS-1:0]  m_text_char,
    input  logic                            m_last_char,
    output int                              chars_pending,
    output int                              mismatch_count
);
    import sidt_pkg::*;

    localparam int EFF_BITS     = (VALUE_BITS < 8) ? 8 : ((VALUE_BITS > 64) ? 64 : VALUE_BITS);
    localparam int MAX_DIGITS   = 19;
    localparam int DECIMAL_BASE = 10;

    typedef struct packed {
        logic [CHAR_BITS-1:0] code;
        logic                 last;
    } text_item_t;

    text_item_t text_due[$];
    int         mismatches   = 0;
    int         pending      = 0;
    int         results_seen = 0;

    assign mismatch_count = mismatches;
    assign chars_pending  = pending;

    task automatic report_mismatch(input string what);
        $display("%0t checker: result %0d: %s", $realtime, results_seen, what);
        mismatches++;
    endtask

    // Append the characters of one integer, sign first, then digits from the top.
    function automatic void predict_decimal_text(input logic [INPUT_BITS-1:0] raw);
        logic [63:0]          top_bit;
        logic [63:0]          mask;
        logic [63:0]          bits;
        logic [63:0]          mag;
        logic                 negative;
        logic [CHAR_BITS-1:0] digit_code [MAX_DIGITS];
        int                   n_digits;
        top_bit  = 64'd1 << (EFF_BITS - 1);
        mask     = (top_bit << 1) - 64'd1;
        bits     = 64'(raw) & mask;
        negative = |(bits & top_bit);
        mag      = negative ? ((~bits + 64'd1) & mask) : bits;
        if (negative && mag == 64'd0)
            mag = top_bit;
        n_digits = 0;
        do begin
            digit_code[n_digits] = CHAR_ZERO + CHAR_BITS'(mag % 64'(DECIMAL_BASE));
            mag = mag / 64'(DECIMAL_BASE);
            n_digits++;
        end while (mag != 64'd0 && n_digits < MAX_DIGITS);
        if (negative)
            text_due.push_back('{code: CHAR_MINUS, last: 1'b0});
        for (int i = n_digits - 1; i >= 0; i--)
            text_due.push_back('{code: digit_code[i], last: (i == 0)});
    endfunction

    always @(posedge aclk) begin : watch_channels
        text_item_t want;
        if (aresetn) begin
            if (s_valid && s_ready)
                predict_decimal_text(s_value);
            if (m_valid && m_ready) begin
                if (text_due.size() == 0) begin
                    report_mismatch($sformatf("char %0d arrived with nothing expected",
                                              m_text_char));
                end else begin
                    want = text_due.pop_front();
                    if (m_text_char !== want.code)
                        report_mismatch($sformatf("text_char %0d, expected %0d",
                                                  m_text_char, want.code));
                    if (m_last_char !== want.last)
                        report_mismatch($sformatf("last_char %b, expected %b",
                                                  m_last_char, want.last));
                end
                results_seen++;
            end
        end
        pending <= text_due.size();
    end

endmodule

[sim/tb.sv]
`timescale 1ns / 100ps
// Top of the signed_integer_to_decimal_text testbench: clock, reset, stimulus
// and result-side stalls. Depends on sidt_pkg, the block and decimal_text_checker.
module tb;
    import sidt_pkg::*;

    localparam int RANDOM_ITEMS = 290;
    localparam int MAX_WAIT     = 8;
    // Cycles after the last expected character: covers one full conversion.
    localparam int TAIL_CYCLES  = 150;
    // Receiver hold-off long enough to back the block up into its input.
    localparam int LONG_HOLD    = 300;

    // Directed integers: zero, single digits, digit-count boundaries, the
    // largest positive and most negative values, and alternating bit patterns.
    localparam logic [INPUT_BITS-1:0] CORNER_VALUES [21] = '{
        64'd0, 64'd1, -64'd1, 64'd9, -64'd9, 64'd10, -64'd10, 64'd99, 64'd100, -64'd100,
        64'd999999999999999999, 64'd1000000000000000000, -64'd1000000000000000000,
        64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0001, 64'h8000_0000_0000_0000,
        64'h0000_0000_FFFF_FFFF, 64'hFFFF_FFFF_0000_0000,
        64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
        64'd1234567890123456789
    };

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    logic [INPUT_BITS-1:0] s_value;
    logic                  m_valid;
    logic                  m_ready;
    logic [CHAR_BITS-1:0]  m_text_char;
    logic                  m_last_char;
    int                    chars_pending;
    int                    mismatch_count;
    int                    items_sent = 0;

    signed_integer_to_decimal_text i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_value     (s_value),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_text_char (m_text_char),
        .m_last_char (m_last_char)
    );

    decimal_text_checker i_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_value        (s_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_text_char    (m_text_char),
        .m_last_char    (m_last_char),
        .chars_pending  (chars_pending),
        .mismatch_count (mismatch_count)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Pick a random integer: full-width noise, random bit lengths, values
    // right at or just below a power of ten, and small values, each with a
    // random sign.
    function automatic logic [INPUT_BITS-1:0] random_integer();
        logic [INPUT_BITS-1:0] mag;
        logic [INPUT_BITS-1:0] scale;
        scale = 64'd1;
        case ($urandom_range(0, 3))
            0: mag = {$urandom, $urandom};
            1: mag = {$urandom, $urandom} >> $urandom_range(0, 63);
            2: begin
                repeat ($urandom_range(0, 18)) scale = scale * 64'd10;
                mag = scale - 64'($urandom_range(0, 1));
            end
            default: mag = 64'($urandom_range(0, 120));
        endcase
        return ($urandom_range(0, 1) != 0) ? -mag : mag;
    endfunction

    // Offer one item after a random gap; hold valid and payload until the
    // handshake. Every fourth stretch of 50 items runs back to back.
    task automatic offer_integer(input logic [INPUT_BITS-1:0] value);
        int gap;
        gap = ((items_sent / 50) % 4 == 3) ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_value <= value;
        do @(posedge aclk); while (!(s_valid && s_ready));
        items_sent++;
    endtask

    // Result side: stall a random number of cycles before every item, run
    // stall-free for a stretch now and then, and twice hold off long enough
    // for the block to fill up and drop s_ready while the sender keeps offering.
    initial begin : result_sink
        int hold;
        int taken;
        taken = 0;
        m_ready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (taken == 40 || taken == 1500)
                hold = LONG_HOLD;
            else if ((taken / 120) % 3 == 2)
                hold = 0;
            else
                hold = $urandom_range(0, MAX_WAIT);
            if (hold > 0) begin
                m_ready <= 1'b0;
                repeat (hold) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
            taken++;
        end
    end

    initial begin : stimulus
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_value <= '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (CORNER_VALUES[i])
            offer_integer(CORNER_VALUES[i]);
        repeat (RANDOM_ITEMS)
            offer_integer(random_integer());
        s_valid <= 1'b0;

        // Advance past the last handshake so the checker has counted the last item,
        // then drain, then give any stray characters time to show up.
        @(posedge aclk);
        wait (chars_pending == 0);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Watchdog: several times the slowest legal run, stalls included.
    initial begin : watchdog
        #6_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
